@@ hdl/number_preserving_gate_engine_defines.svh @@
// Assertion macros used by the port-level checker.
`ifndef NUMBER_PRESERVING_GATE_ENGINE_DEFINES_SVH
`define NUMBER_PRESERVING_GATE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define NPG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npg check failed");

// Next-cycle implication, disabled in reset.
`define NPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npg check failed");

// Next-cycle implication that also holds across reset.
`define NPG_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("npg check failed");

`endif

@@ hdl/npg_pkg.sv @@
// Package: types, codes and constants of the gate engine.
`timescale 1ns / 1ps
`default_nettype none
package npg_pkg;

  localparam int MAX_QUBITS_DEF = 10;
  localparam int AMP_BITS_DEF   = 16;
  localparam int CFG_W          = 4;
  localparam int CFG_IDX_W      = 1;
  localparam int QB_W           = 4;
  localparam int GATE_W         = 4;
  localparam int ACT_W          = 2;
  localparam int K_SHIFT        = 30;
  localparam logic [30:0] INV_SQRT2_Q30 = 31'd759250125;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_QUBITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POP_TARGET = 1'd1;

  localparam logic [CFG_W-1:0] NUM_QUBITS_RST = 4'd10;
  localparam logic [CFG_W-1:0] POP_TARGET_RST = 4'd1;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_GATE  = 2'd2;

  localparam logic [GATE_W-1:0] G_PHASE  = 4'd0;
  localparam logic [GATE_W-1:0] G_Z      = 4'd1;
  localparam logic [GATE_W-1:0] G_RZ     = 4'd2;
  localparam logic [GATE_W-1:0] G_CZ     = 4'd3;
  localparam logic [GATE_W-1:0] G_CRZ    = 4'd4;
  localparam logic [GATE_W-1:0] G_CPHASE = 4'd5;
  localparam logic [GATE_W-1:0] G_SWAP   = 4'd6;
  localparam logic [GATE_W-1:0] G_FSWAP  = 4'd7;
  localparam logic [GATE_W-1:0] G_NPRX   = 4'd8;
  localparam logic [GATE_W-1:0] G_NPRY   = 4'd9;
  localparam logic [GATE_W-1:0] G_NPH    = 4'd10;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_SCAN, ST_RDP, ST_RDQ, ST_MULA, ST_ADDA,
    ST_MULB, ST_ADDB, ST_WRP, ST_WRQ, ST_FIN
  } st_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_NEG, OP_CMUL, OP_SWAP, OP_RX, OP_RY, OP_H
  } op_t;

  typedef struct packed {
    op_t  op;
    logic phase_b;
    logic sneg;
  } alu_ctl_t;

endpackage
`default_nettype wire

@@ hdl/npg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module npg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/npg_alu.sv @@
// Four registered multipliers and the round/saturate combine stage.
`timescale 1ns / 1ps
`default_nettype none
module npg_alu import npg_pkg::*; #(
  parameter int AMP_BITS = AMP_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire alu_ctl_t                   ctl,
  input  wire logic signed [AMP_BITS-1:0] p_re,
  input  wire logic signed [AMP_BITS-1:0] p_im,
  input  wire logic signed [AMP_BITS-1:0] q_re,
  input  wire logic signed [AMP_BITS-1:0] q_im,
  input  wire logic signed [AMP_BITS-1:0] coef_c,
  input  wire logic signed [AMP_BITS-1:0] coef_s,
  output logic      signed [AMP_BITS-1:0] res_re,
  output logic      signed [AMP_BITS-1:0] res_im
);

  localparam int F   = AMP_BITS - 1;
  localparam int AW  = AMP_BITS + 1;
  localparam int BW  = (AMP_BITS + 1 > 31) ? AMP_BITS + 1 : 31;
  localparam int PRW = AW + BW;
  localparam int SW  = PRW + 1;

  localparam logic signed [SW-1:0] RND_F = SW'(1) << (F - 1);
  localparam logic signed [SW-1:0] RND_K = SW'(1) << (K_SHIFT - 1);
  localparam logic signed [SW-1:0] HI = {{(SW-AMP_BITS+1){1'b0}}, {F{1'b1}}};
  localparam logic signed [SW-1:0] LO = {{(SW-AMP_BITS+1){1'b1}}, {F{1'b0}}};

  logic signed [AW-1:0]  a [4];
  logic signed [BW-1:0]  b [4];
  logic signed [PRW-1:0] m_r [4];
  logic                  hmode_r;
  logic signed [AW-1:0]  c_a, s_a, sv_a;
  logic signed [BW-1:0]  k_b;

  always_comb begin
    c_a  = AW'(coef_c);
    s_a  = AW'(coef_s);
    sv_a = ctl.sneg ? -s_a : s_a;
    k_b  = BW'(INV_SQRT2_Q30);
    for (int i = 0; i < 4; i++) begin
      a[i] = '0;
      b[i] = '0;
    end
    unique case (ctl.op)
      OP_CMUL: begin
        a[0] = c_a;   b[0] = BW'(p_re);
        a[1] = -sv_a; b[1] = BW'(p_im);
        a[2] = c_a;   b[2] = BW'(p_im);
        a[3] = sv_a;  b[3] = BW'(p_re);
      end
      OP_RX: begin
        a[0] = c_a;  b[0] = ctl.phase_b ? BW'(q_re) : BW'(p_re);
        a[1] = s_a;  b[1] = ctl.phase_b ? BW'(p_im) : BW'(q_im);
        a[2] = c_a;  b[2] = ctl.phase_b ? BW'(q_im) : BW'(p_im);
        a[3] = -s_a; b[3] = ctl.phase_b ? BW'(p_re) : BW'(q_re);
      end
      OP_RY: begin
        a[0] = ctl.phase_b ? s_a : c_a;  b[0] = BW'(p_re);
        a[1] = ctl.phase_b ? c_a : -s_a; b[1] = BW'(q_re);
        a[2] = ctl.phase_b ? s_a : c_a;  b[2] = BW'(p_im);
        a[3] = ctl.phase_b ? c_a : -s_a; b[3] = BW'(q_im);
      end
      OP_H: begin
        a[0] = ctl.phase_b ? AW'(p_re) - AW'(q_re) : AW'(p_re) + AW'(q_re);
        b[0] = k_b;
        a[2] = ctl.phase_b ? AW'(p_im) - AW'(q_im) : AW'(p_im) + AW'(q_im);
        b[2] = k_b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m_r[i] <= PRW'(a[i]) * PRW'(b[i]);
    end
    hmode_r <= (ctl.op == OP_H);
  end

  logic signed [SW-1:0] sum_re, sum_im, sh_re, sh_im;

  always_comb begin
    sum_re = SW'(m_r[0]) + SW'(m_r[1]) + (hmode_r ? RND_K : RND_F);
    sum_im = SW'(m_r[2]) + SW'(m_r[3]) + (hmode_r ? RND_K : RND_F);
    sh_re  = hmode_r ? (sum_re >>> K_SHIFT) : (sum_re >>> F);
    sh_im  = hmode_r ? (sum_im >>> K_SHIFT) : (sum_im >>> F);
    if (sh_re > HI) res_re = HI[AMP_BITS-1:0];
    else if (sh_re < LO) res_re = LO[AMP_BITS-1:0];
    else res_re = sh_re[AMP_BITS-1:0];
    if (sh_im > HI) res_im = HI[AMP_BITS-1:0];
    else if (sh_im < LO) res_im = LO[AMP_BITS-1:0];
    else res_im = sh_im[AMP_BITS-1:0];
  end

endmodule
`default_nettype wire

@@ hdl/number_preserving_gate_engine.sv @@
// Top level: amplitude store, index walk sequencer and result register.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | action, address, amplitude, gate fields
//  out_    | output    | out_valid / out_ready  | status, read_real, read_imag
//  cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// A write or an errored item passes IDLE and FIN, a read also RD. A gate walks all
// 2^num_qubits RAM indexes, each in SCAN; a negation adds RDP, WRP, a one-amplitude
// product RDP, MULA, ADDA, WRP, a swap RDP, RDQ, WRP, WRQ, a pair rotation RDP, RDQ,
// MULA, ADDA, MULB, ADDB, WRP, WRQ. The RAM's one read and one write port set this.
// Reset (rst_n low, synchronous) clears control and config; the RAM keeps no
// reset. FIN waits while an earlier result is still offered and out_ready is low.
`timescale 1ns / 1ps
`default_nettype none
module number_preserving_gate_engine import npg_pkg::*; #(
  parameter int MAX_QUBITS = MAX_QUBITS_DEF,
  parameter int AMP_BITS   = AMP_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ACT_W-1:0]             in_action,
  input  wire logic [MAX_QUBITS-1:0]        in_address,
  input  wire logic signed [AMP_BITS-1:0]   in_amp_real,
  input  wire logic signed [AMP_BITS-1:0]   in_amp_imag,
  input  wire logic [GATE_W-1:0]            in_gate,
  input  wire logic [QB_W-1:0]              in_qubit_a,
  input  wire logic [QB_W-1:0]              in_qubit_b,
  input  wire logic signed [AMP_BITS-1:0]   in_coef_cos,
  input  wire logic signed [AMP_BITS-1:0]   in_coef_sin,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_status,
  output logic signed [AMP_BITS-1:0]        out_read_real,
  output logic signed [AMP_BITS-1:0]        out_read_imag,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_wdata
);

  localparam int F    = AMP_BITS - 1;
  localparam int DW   = 2 * AMP_BITS;
  localparam int NQW  = $clog2(MAX_QUBITS + 1);
  localparam int PW   = NQW;
  localparam int CMPW = ((NQW > QB_W) ? NQW : QB_W) + 1;
  localparam logic signed [AMP_BITS-1:0] AMIN = {1'b1, {F{1'b0}}};
  localparam logic signed [AMP_BITS-1:0] AMAX = {1'b0, {F{1'b1}}};

  // control and config registers
  st_t                    st_r, st_nxt;
  logic [CFG_W-1:0]       num_qubits_r, pop_target_r;
  logic                   out_valid_r;
  // item and walk registers
  logic [MAX_QUBITS-1:0]  x_r;
  logic [GATE_W-1:0]      gate_r;
  logic [QB_W-1:0]        qa_r, qb_r;
  logic signed [AMP_BITS-1:0] c_r, s_r;
  op_t                    op_r;
  logic                   sneg_r;
  logic                   status_r;
  logic signed [AMP_BITS-1:0] p_re_r, p_im_r, q_re_r, q_im_r;
  logic signed [AMP_BITS-1:0] n1_re_r, n1_im_r, n2_re_r, n2_im_r;
  logic signed [AMP_BITS-1:0] rd_re_r, rd_im_r;
  logic                   out_status_r;
  logic signed [AMP_BITS-1:0] out_re_r, out_im_r;

  // effective qubit count, clamped into range
  logic [NQW-1:0]         nq_eff;
  logic [MAX_QUBITS-1:0]  idx_mask;
  logic                   addr_ok, gate_ok, item_bad;

  always_comb begin
    if (num_qubits_r < CFG_W'(2)) nq_eff = NQW'(2);
    else if (CMPW'(num_qubits_r) > CMPW'(MAX_QUBITS)) nq_eff = NQW'(MAX_QUBITS);
    else nq_eff = NQW'(num_qubits_r);
    idx_mask = ~({MAX_QUBITS{1'b1}} << nq_eff);
    addr_ok  = ((in_address & ~idx_mask) == '0);
    if (in_gate > G_NPH) gate_ok = 1'b0;
    else if (in_gate <= G_RZ) gate_ok = CMPW'(in_qubit_b) < CMPW'(nq_eff);
    else gate_ok = (CMPW'(in_qubit_a) < CMPW'(nq_eff)) &&
                   (CMPW'(in_qubit_b) < CMPW'(nq_eff)) && (in_qubit_a != in_qubit_b);
    priority case (in_action)
      ACT_WRITE, ACT_READ: item_bad = !addr_ok;
      ACT_GATE:            item_bad = !gate_ok;
      default:             item_bad = 1'b1;
    endcase
  end

  // classify the current walk index
  logic [MAX_QUBITS-1:0] ba, bb, q_addr;
  logic                  ha, hb, pc_match, x_last;
  logic [PW-1:0]         pc;
  op_t                   op_scan;
  logic                  sneg_scan;

  always_comb begin
    ba     = MAX_QUBITS'(1) << qa_r;
    bb     = MAX_QUBITS'(1) << qb_r;
    ha     = |(x_r & ba);
    hb     = |(x_r & bb);
    q_addr = x_r ^ ba ^ bb;
    x_last = (x_r == idx_mask);
    pc     = '0;
    for (int i = 0; i < MAX_QUBITS; i++) begin
      pc = pc + PW'(x_r[i]);
    end
    pc_match  = (CMPW'(pc) == CMPW'(pop_target_r));
    op_scan   = OP_NONE;
    sneg_scan = 1'b0;
    unique case (gate_r)
      G_PHASE:  if (hb) op_scan = OP_CMUL;
      G_Z:      if (hb) op_scan = OP_NEG;
      G_RZ: begin
        op_scan   = OP_CMUL;
        sneg_scan = !hb;
      end
      G_CZ:     if (ha && hb) op_scan = OP_NEG;
      G_CRZ: begin
        if (ha) op_scan = OP_CMUL;
        sneg_scan = !hb;
      end
      G_CPHASE: if (ha && hb) op_scan = OP_CMUL;
      G_SWAP:   if (ha && !hb) op_scan = OP_SWAP;
      G_FSWAP: begin
        if (ha && hb) op_scan = OP_NEG;
        else if (ha) op_scan = OP_SWAP;
      end
      G_NPRX:   if (ha && !hb) op_scan = OP_RX;
      G_NPRY:   if (ha && !hb) op_scan = OP_RY;
      G_NPH:    if (ha && !hb) op_scan = OP_H;
      default:  op_scan = OP_NONE;
    endcase
    if (!pc_match) op_scan = OP_NONE;
  end

  logic pair_op;
  assign pair_op = (op_r == OP_SWAP) || (op_r == OP_RX) || (op_r == OP_RY) ||
                   (op_r == OP_H);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (item_bad) st_nxt = ST_FIN;
          else if (in_action == ACT_READ) st_nxt = ST_RD;
          else if (in_action == ACT_GATE) st_nxt = ST_SCAN;
          else st_nxt = ST_FIN;
        end
      end
      ST_RD:   st_nxt = ST_FIN;
      ST_SCAN: begin
        if (op_scan != OP_NONE) st_nxt = ST_RDP;
        else if (x_last) st_nxt = ST_FIN;
      end
      ST_RDP: begin
        if (op_r == OP_NEG) st_nxt = ST_WRP;
        else if (op_r == OP_CMUL) st_nxt = ST_MULA;
        else st_nxt = ST_RDQ;
      end
      ST_RDQ:  st_nxt = (op_r == OP_SWAP) ? ST_WRP : ST_MULA;
      ST_MULA: st_nxt = ST_ADDA;
      ST_ADDA: st_nxt = (op_r == OP_CMUL) ? ST_WRP : ST_MULB;
      ST_MULB: st_nxt = ST_ADDB;
      ST_ADDB: st_nxt = ST_WRP;
      ST_WRP: begin
        if (pair_op) st_nxt = ST_WRQ;
        else st_nxt = x_last ? ST_FIN : ST_SCAN;
      end
      ST_WRQ:  st_nxt = x_last ? ST_FIN : ST_SCAN;
      ST_FIN:  if (!out_valid_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs: RAM port, ALU control, handshake
  logic                  ram_we;
  logic [MAX_QUBITS-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0]         ram_wdata, ram_rdata;
  logic                  x_adv, out_load;
  alu_ctl_t              alu_ctl;
  logic signed [AMP_BITS-1:0] neg_re, neg_im, alu_re, alu_im;

  always_comb begin
    neg_re = (p_re_r == AMIN) ? AMAX : -p_re_r;
    neg_im = (p_im_r == AMIN) ? AMAX : -p_im_r;
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = x_r;
    ram_wdata = {n1_re_r, n1_im_r};
    ram_raddr = x_r;
    x_adv     = 1'b0;
    out_load  = 1'b0;
    alu_ctl   = '{op: op_r, phase_b: (st_r == ST_MULB), sneg: sneg_r};
    unique case (st_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = in_address;
        ram_waddr = in_address;
        ram_wdata = {in_amp_real, in_amp_imag};
        ram_we    = in_valid && !item_bad && (in_action == ACT_WRITE);
      end
      ST_SCAN: x_adv = (op_scan == OP_NONE) && !x_last;
      ST_RDP:  ram_raddr = q_addr;
      ST_WRP: begin
        ram_we = 1'b1;
        if (op_r == OP_NEG) ram_wdata = {neg_re, neg_im};
        else if (op_r == OP_SWAP) ram_wdata = {q_re_r, q_im_r};
        x_adv = !pair_op && !x_last;
      end
      ST_WRQ: begin
        ram_we    = 1'b1;
        ram_waddr = q_addr;
        ram_wdata = (op_r == OP_SWAP) ? {p_re_r, p_im_r} : {n2_re_r, n2_im_r};
        x_adv     = !x_last;
      end
      ST_FIN:  out_load = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  npg_ram #(
    .WIDTH (DW),
    .DEPTH (1 << MAX_QUBITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  npg_alu #(
    .AMP_BITS (AMP_BITS)
  ) u_alu (
    .clk    (clk),
    .ctl    (alu_ctl),
    .p_re   (p_re_r),
    .p_im   (p_im_r),
    .q_re   (q_re_r),
    .q_im   (q_im_r),
    .coef_c (c_r),
    .coef_s (s_r),
    .res_re (alu_re),
    .res_im (alu_im)
  );

  // control state: reset clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_valid_r  <= 1'b0;
      num_qubits_r <= NUM_QUBITS_RST;
      pop_target_r <= POP_TARGET_RST;
    end else begin
      st_r <= st_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_QUBITS: num_qubits_r <= cfg_wdata;
          CFG_POP_TARGET: pop_target_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_valid) begin
      gate_r   <= in_gate;
      qa_r     <= in_qubit_a;
      qb_r     <= in_qubit_b;
      c_r      <= in_coef_cos;
      s_r      <= in_coef_sin;
      status_r <= item_bad;
      rd_re_r  <= '0;
      rd_im_r  <= '0;
      x_r      <= '0;
    end else if (x_adv) begin
      x_r <= x_r + MAX_QUBITS'(1);
    end
    if (st_r == ST_SCAN) begin
      op_r   <= op_scan;
      sneg_r <= sneg_scan;
    end
    if (st_r == ST_RD) begin
      rd_re_r <= ram_rdata[DW-1:AMP_BITS];
      rd_im_r <= ram_rdata[AMP_BITS-1:0];
    end
    if (st_r == ST_RDP) begin
      p_re_r <= ram_rdata[DW-1:AMP_BITS];
      p_im_r <= ram_rdata[AMP_BITS-1:0];
    end
    if (st_r == ST_RDQ) begin
      q_re_r <= ram_rdata[DW-1:AMP_BITS];
      q_im_r <= ram_rdata[AMP_BITS-1:0];
    end
    if (st_r == ST_ADDA) begin
      n1_re_r <= alu_re;
      n1_im_r <= alu_im;
    end
    if (st_r == ST_ADDB) begin
      n2_re_r <= alu_re;
      n2_im_r <= alu_im;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_re_r     <= rd_re_r;
      out_im_r     <= rd_im_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_real = out_re_r;
  assign out_read_imag = out_im_r;

endmodule
`default_nettype wire

@@ hdl/npg_chk.sv @@
// Port-level checker for the gate engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "number_preserving_gate_engine_defines.svh"
module npg_chk import npg_pkg::*; #(
  parameter int AMP_BITS = AMP_BITS_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_status,
  input wire logic signed [AMP_BITS-1:0] out_read_real,
  input wire logic signed [AMP_BITS-1:0] out_read_imag
);

  // one transaction at a time: taking an item drops ready
  `NPG_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // a failed item reports a zero amplitude
  `NPG_ASSERT_NOW(a_err_zero, out_valid && out_status, (out_read_real == '0) && (out_read_imag == '0))
  // a waiting result stays offered
  `NPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // nothing is offered right after reset
  `NPG_ASSERT_ALWAYS(a_rst_quiet, !rst_n, !out_valid)

endmodule

bind number_preserving_gate_engine npg_chk #(.AMP_BITS(AMP_BITS)) u_npg_chk (.*);
`default_nettype wire
